// ===== hw/rtl/nvmeqp_pkg.sv =====
// Shared types, constants and pointer helpers for the NVMe queue pair tracker.
package nvmeqp_pkg;

  localparam int PTR_W      = 10;
  localparam int OFF_W      = 16;
  localparam int SQID_W     = 16;
  localparam int QID_W      = 4;
  localparam int CMD_W      = 3;
  localparam int SIZE_W     = 11;
  localparam int EB_W       = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  localparam logic [SIZE_W-1:0] RING_MIN = 11'd2;
  localparam logic [SIZE_W-1:0] RING_CAP = 11'd1024;
  localparam logic [EB_W-1:0]   EB_MIN   = 7'd1;
  localparam logic [EB_W-1:0]   EB_MAX   = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_SQ_ENQ  = 3'd0,
    CMD_CQ_POLL = 3'd1,
    CMD_CQ_DEQ  = 3'd2,
    CMD_SQ_DB   = 3'd3,
    CMD_CQ_DB   = 3'd4
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_SQ_ENTRIES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CQ_ENTRIES = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQ_EBYTES  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CQ_EBYTES  = 8'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [QID_W-1:0]  queue_id;
    logic              cqe_phase;
    logic [SQID_W-1:0] cqe_sq_id;
    logic [PTR_W-1:0]  cqe_sq_head;
  } in_item_t;

  typedef struct packed {
    logic             ready_res;
    logic [PTR_W-1:0] slot_index;
    logic [OFF_W-1:0] slot_offset;
    logic [PTR_W-1:0] command_id;
    logic [PTR_W-1:0] doorbell_value;
    logic             bad_queue;
  } out_item_t;

  // Write side of the submission queue pointer tables.
  typedef struct packed {
    logic             tail_we;
    logic [PTR_W-1:0] tail_data;
    logic             head_we;
    logic [PTR_W-1:0] head_data;
  } tbl_wr_t;

  function automatic logic [SIZE_W-1:0] ring_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < RING_MIN) r = RING_MIN;
    if (v > RING_CAP) r = RING_CAP;
    return r;
  endfunction

  function automatic logic [EB_W-1:0] entry_bytes(input logic [EB_W-1:0] v);
    logic [EB_W-1:0] r;
    r = v;
    if (v < EB_MIN) r = EB_MIN;
    if (v > EB_MAX) r = EB_MAX;
    return r;
  endfunction

  // Step a ring pointer; anything at or past the ring size goes to zero.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    n = {1'b0, p} + SIZE_W'(1);
    return (n >= size) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/nvmeqp_sq_table.sv =====
// Submission queue tail and head pointer memories with per-entry valid bits.
module nvmeqp_sq_table
  import nvmeqp_pkg::*;
#(
  parameter int MAX_QUEUES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [((MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1)-1:0] rd_addr,
  input  tbl_wr_t              wr,
  input  logic [((MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1)-1:0] tail_waddr,
  input  logic [((MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1)-1:0] head_waddr,
  output logic [PTR_W-1:0]     tail_q,
  output logic [PTR_W-1:0]     head_q
);

  logic [PTR_W-1:0]      tail_mem [MAX_QUEUES];
  logic [PTR_W-1:0]      head_mem [MAX_QUEUES];
  logic [MAX_QUEUES-1:0] tail_vld_r;
  logic [MAX_QUEUES-1:0] head_vld_r;
  logic [PTR_W-1:0]      tail_rd_r;
  logic [PTR_W-1:0]      head_rd_r;
  logic                  tail_hit_r;
  logic                  head_hit_r;

  always_ff @(posedge clk) begin
    if (wr.tail_we) begin
      tail_mem[tail_waddr] <= wr.tail_data;
    end
    if (wr.head_we) begin
      head_mem[head_waddr] <= wr.head_data;
    end
  end

  // Entries never written read as zero, the reset value of both tables.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_vld_r <= '0;
      head_vld_r <= '0;
    end else begin
      if (wr.tail_we) tail_vld_r[tail_waddr] <= 1'b1;
      if (wr.head_we) head_vld_r[head_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tail_rd_r  <= tail_mem[rd_addr];
      head_rd_r  <= head_mem[rd_addr];
      tail_hit_r <= tail_vld_r[rd_addr];
      head_hit_r <= head_vld_r[rd_addr];
    end
  end

  assign tail_q = tail_hit_r ? tail_rd_r : '0;
  assign head_q = head_hit_r ? head_rd_r : '0;

`ifndef SYNTHESIS
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !(wr.tail_we || wr.head_we))
    else $error("pointer table read and write in the same cycle");

  a_tail_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr.tail_we |=> tail_vld_r[$past(tail_waddr)])
    else $error("tail entry not marked valid after write");

  a_head_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr.head_we |=> head_vld_r[$past(head_waddr)])
    else $error("head entry not marked valid after write");
`endif

endmodule

// ===== hw/rtl/nvme_queue_pair_tracker_core.sv =====
// Top level of the NVMe queue pair tracker: command sequencer, CQ state, config.
//
// Usage:
//   Drive in_item and raise start; the command is taken at the rising edge where
//   start is high and busy is low. busy is high for the one cycle in which the
//   command executes.
//   Each command yields exactly one result beat: out_valid is high for one cycle
//   with out_item. The receiver cannot stall; the beat is taken at the edge that
//   ends that cycle.
//   The command is registered with the state into execute; the result is then
//   registered into out_item_r and shown on the ports with out_valid.
//   No new command is taken while busy. The submission queue tail and
//   head tables are synchronous memories with a registered read; the read is
//   issued at accept and the read-modify-write finishes in the execute cycle,
//   so busy interlocks the next read behind the write-back.
//   A new command may be accepted in the same cycle that the previous result
//   beat is shown.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write only while no command is in flight.
//   Reset (rst_n low, synchronous): pointer tables read as zero through per-entry
//   valid bits, no clearing pass; CQ head 0, expected phase 1, ring sizes 64,
//   entry sizes 64 (SQ) and 16 (CQ) bytes.
module nvme_queue_pair_tracker_core
  import nvmeqp_pkg::*;
#(
  parameter int MAX_QUEUES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t            state_r;
  in_item_t          item_r;
  out_item_t         out_item_r;
  logic              out_valid_r;
  logic [PTR_W-1:0]  cq_head_r;
  logic [PTR_W-1:0]  cq_head_nxt;
  logic              phase_r;
  logic              phase_nxt;
  logic [SIZE_W-1:0] sq_entries_r;
  logic [SIZE_W-1:0] cq_entries_r;
  logic [EB_W-1:0]   sq_eb_r;
  logic [EB_W-1:0]   cq_eb_r;

  logic              exec;
  logic              accept;
  logic [PTR_W-1:0]  tail_q;
  logic [PTR_W-1:0]  head_q;
  logic [PTR_W-1:0]  next_tail;
  logic [SIZE_W-1:0] cq_inc;
  logic              sq_ok;
  logic              cqid_ok;
  tbl_wr_t           wr_cmd;
  tbl_wr_t           tbl_wr;
  out_item_t         res;
  logic [PTR_W-1:0]  mul_idx;
  logic [EB_W-1:0]   mul_eb;
  logic [PTR_W+EB_W-1:0] mul_prod;

  assign exec      = (state_r == ST_EXEC);
  assign busy      = exec;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  nvmeqp_sq_table #(
    .MAX_QUEUES(MAX_QUEUES)
  ) u_sq_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr   (QW'(in_item.queue_id)),
    .wr        (tbl_wr),
    .tail_waddr(QW'(item_r.queue_id)),
    .head_waddr(QW'(item_r.cqe_sq_id)),
    .tail_q    (tail_q),
    .head_q    (head_q)
  );

  // Queue ids past the table are flagged and never write the memories.
  assign sq_ok     = 32'(item_r.queue_id) < MAX_QUEUES;
  assign cqid_ok   = 32'(item_r.cqe_sq_id) < MAX_QUEUES;
  assign next_tail = advance(tail_q, ring_size(sq_entries_r));
  assign cq_inc    = {1'b0, cq_head_r} + SIZE_W'(1);
  assign mul_prod  = mul_idx * mul_eb;

  always_comb begin
    res         = '0;
    wr_cmd      = '0;
    cq_head_nxt = cq_head_r;
    phase_nxt   = phase_r;
    mul_idx     = '0;
    mul_eb      = '0;
    case (item_r.command)
      CMD_SQ_ENQ: begin
        if (!sq_ok) begin
          res.bad_queue = 1'b1;
        end else begin
          res.slot_index = tail_q;
          mul_idx        = tail_q;
          mul_eb         = entry_bytes(sq_eb_r);
          // Full when the advanced tail would land on the head: hold the tail.
          if (next_tail != head_q) begin
            res.ready_res    = 1'b1;
            res.command_id   = next_tail;
            wr_cmd.tail_we   = 1'b1;
            wr_cmd.tail_data = next_tail;
          end
        end
      end
      CMD_CQ_POLL, CMD_CQ_DEQ: begin
        res.slot_index = cq_head_r;
        mul_idx        = cq_head_r;
        mul_eb         = entry_bytes(cq_eb_r);
        if (item_r.cqe_phase == phase_r) begin
          res.ready_res = 1'b1;
          if (item_r.command == CMD_CQ_DEQ) begin
            // Advance the head; flip the expected phase on wrap.
            if (cq_inc >= ring_size(cq_entries_r)) begin
              cq_head_nxt = '0;
              phase_nxt   = ~phase_r;
            end else begin
              cq_head_nxt = cq_inc[PTR_W-1:0];
            end
            if (cqid_ok) begin
              wr_cmd.head_we   = 1'b1;
              wr_cmd.head_data = item_r.cqe_sq_head;
            end else begin
              res.bad_queue = 1'b1;
            end
          end
        end
      end
      CMD_SQ_DB: begin
        if (!sq_ok) begin
          res.bad_queue = 1'b1;
        end else begin
          res.ready_res      = 1'b1;
          res.doorbell_value = tail_q;
        end
      end
      CMD_CQ_DB: begin
        res.ready_res      = 1'b1;
        res.doorbell_value = cq_head_r;
      end
      default: begin
        res = '0;
      end
    endcase
    res.slot_offset = mul_prod[OFF_W-1:0];
  end

  // Write back only in the execute cycle.
  always_comb begin
    tbl_wr         = wr_cmd;
    tbl_wr.tail_we = wr_cmd.tail_we && exec;
    tbl_wr.head_we = wr_cmd.head_we && exec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      out_item_r   <= '0;
      item_r       <= '0;
      cq_head_r    <= '0;
      phase_r      <= 1'b1;
      sq_entries_r <= 11'd64;
      cq_entries_r <= 11'd64;
      sq_eb_r      <= 7'd64;
      cq_eb_r      <= 7'd16;
    end else begin
      case (state_r)
        ST_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            item_r  <= in_item;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid_r <= 1'b1;
          out_item_r  <= res;
          cq_head_r   <= cq_head_nxt;
          phase_r     <= phase_nxt;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SQ_ENTRIES: sq_entries_r <= cfg_data;
          REG_CQ_ENTRIES: cq_entries_r <= cfg_data;
          REG_SQ_EBYTES:  sq_eb_r      <= cfg_data[EB_W-1:0];
          REG_CQ_EBYTES:  cq_eb_r      <= cfg_data[EB_W-1:0];
          default: begin
            sq_entries_r <= sq_entries_r;
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not enter execute");

  a_exec_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute cycle did not produce exactly one result beat");

  a_cq_head_moves_on_deq: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && (cq_head_nxt != cq_head_r)) |-> (item_r.command == CMD_CQ_DEQ))
    else $error("completion head moved on a command other than dequeue");
`endif

endmodule

// ===== bench/nvmeqp_ring_checker.sv =====
// Scoreboard for the NVMe queue pair tracker: shadow ring state, expected beats, compare.
`timescale 1ns / 100ps
module nvmeqp_ring_checker
  import nvmeqp_pkg::*;
#(
  parameter int MAX_QUEUES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output logic                  cq_phase_hint
);

  localparam int REPORT_LIMIT = 10;

  logic [PTR_W-1:0]  sq_tail_shadow [MAX_QUEUES];
  logic [PTR_W-1:0]  sq_head_shadow [MAX_QUEUES];
  logic [PTR_W-1:0]  cq_head;
  logic              cq_phase;
  logic [SIZE_W-1:0] sq_slots_reg;
  logic [SIZE_W-1:0] cq_slots_reg;
  logic [EB_W-1:0]   sq_bytes_reg;
  logic [EB_W-1:0]   cq_bytes_reg;
  out_item_t         pending_beats [$];
  int                fail_cnt = 0;
  int                depth = 0;

  assign mismatches    = fail_cnt;
  assign outstanding   = depth;
  assign cq_phase_hint = cq_phase;

  function automatic int ring_slots(input logic [SIZE_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > 1024) return 1024;
    return int'(raw);
  endfunction

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p, input int slots);
    int n;
    n = int'(p) + 1;
    if (n >= slots) return '0;
    return n[PTR_W-1:0];
  endfunction

  function automatic logic [OFF_W-1:0] byte_offset(input logic [PTR_W-1:0] p,
                                                   input logic [EB_W-1:0] raw);
    int b;
    int prod;
    b = (raw == 0) ? 1 : ((raw > 64) ? 64 : int'(raw));
    prod = int'(p) * b;
    return prod[OFF_W-1:0];
  endfunction

  // Work out the beat for one command and advance the shadow state.
  task automatic apply_ring_op(input in_item_t it, output out_item_t res);
    logic [PTR_W-1:0] nxt;
    logic [PTR_W-1:0] tail;
    res = '0;
    case (it.command)
      CMD_SQ_ENQ: begin
        if (int'(it.queue_id) >= MAX_QUEUES) begin
          res.bad_queue = 1'b1;
        end else begin
          tail = sq_tail_shadow[it.queue_id];
          nxt  = step_ptr(tail, ring_slots(sq_slots_reg));
          res.slot_index  = tail;
          res.slot_offset = byte_offset(tail, sq_bytes_reg);
          // full when the advanced tail would land on the head
          if (nxt != sq_head_shadow[it.queue_id]) begin
            res.ready_res = 1'b1;
            res.command_id = nxt;
            sq_tail_shadow[it.queue_id] = nxt;
          end
        end
      end
      CMD_CQ_POLL, CMD_CQ_DEQ: begin
        res.slot_index  = cq_head;
        res.slot_offset = byte_offset(cq_head, cq_bytes_reg);
        if (it.cqe_phase == cq_phase) begin
          res.ready_res = 1'b1;
          if (it.command == CMD_CQ_DEQ) begin
            if (int'(cq_head) + 1 >= ring_slots(cq_slots_reg)) begin
              cq_head  = '0;
              cq_phase = ~cq_phase;
            end else begin
              cq_head = cq_head + 1'b1;
            end
            if (int'(it.cqe_sq_id) < MAX_QUEUES) begin
              sq_head_shadow[it.cqe_sq_id] = it.cqe_sq_head;
            end else begin
              res.bad_queue = 1'b1;
            end
          end
        end
      end
      CMD_SQ_DB: begin
        if (int'(it.queue_id) >= MAX_QUEUES) begin
          res.bad_queue = 1'b1;
        end else begin
          res.ready_res = 1'b1;
          res.doorbell_value = sq_tail_shadow[it.queue_id];
        end
      end
      CMD_CQ_DB: begin
        res.ready_res = 1'b1;
        res.doorbell_value = cq_head;
      end
      default: ;
    endcase
  endtask

  task automatic report_beat(input string what, input out_item_t want, input out_item_t got);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT) begin
      $display("%0t: %s: exp rdy=%0d idx=%0d off=%0d cid=%0d db=%0d bad=%0d", $realtime, what,
               want.ready_res, want.slot_index, want.slot_offset, want.command_id,
               want.doorbell_value, want.bad_queue);
      $display("%0t: %s: got rdy=%0d idx=%0d off=%0d cid=%0d db=%0d bad=%0d", $realtime, what,
               got.ready_res, got.slot_index, got.slot_offset, got.command_id,
               got.doorbell_value, got.bad_queue);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int q = 0; q < MAX_QUEUES; q++) begin
        sq_tail_shadow[q] = '0;
        sq_head_shadow[q] = '0;
      end
      cq_head      = '0;
      cq_phase     = 1'b1;
      sq_slots_reg = 11'd64;
      cq_slots_reg = 11'd64;
      sq_bytes_reg = 7'd64;
      cq_bytes_reg = 7'd16;
      pending_beats.delete();
    end else begin
      // retire the beat on the bus before taking in a new command
      if (out_valid) begin
        if (pending_beats.size() == 0) begin
          report_beat("unexpected beat", '0, out_item);
        end else begin
          want = pending_beats.pop_front();
          if (out_item.ready_res !== want.ready_res ||
              out_item.slot_index !== want.slot_index ||
              out_item.slot_offset !== want.slot_offset ||
              out_item.command_id !== want.command_id ||
              out_item.doorbell_value !== want.doorbell_value ||
              out_item.bad_queue !== want.bad_queue) begin
            report_beat("mismatch", want, out_item);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SQ_ENTRIES: sq_slots_reg = cfg_data;
          REG_CQ_ENTRIES: cq_slots_reg = cfg_data;
          REG_SQ_EBYTES:  sq_bytes_reg = cfg_data[EB_W-1:0];
          REG_CQ_EBYTES:  cq_bytes_reg = cfg_data[EB_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        apply_ring_op(in_item, want);
        pending_beats.push_back(want);
      end
    end
    depth = pending_beats.size();
  end

endmodule

// ===== bench/nvme_queue_pair_tracker_core_tb.sv =====
// Stimulus and verdict for the NVMe queue pair tracker core.
`timescale 1ns / 100ps
module nvme_queue_pair_tracker_core_tb;
  import nvmeqp_pkg::*;

  localparam int MAX_QUEUES   = 16;
  // Longest legal quiet stretch is the largest random gap plus the busy interlock;
  // the end-of-phase drain adds DRAIN_CYCLES more. Leave a wide margin.
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 210;
  localparam int IDLE_BLOCK   = 40;
  // Command codes the block does not decode; they must come back as an all-zero beat.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   mismatches;
  int   outstanding;
  logic cq_phase_hint;
  int   gap_max = 0;
  int   sq_slots_now = 64;
  int   quiet_cycles = 0;

  always #5 clk = ~clk;

  nvme_queue_pair_tracker_core #(.MAX_QUEUES(MAX_QUEUES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nvmeqp_ring_checker #(.MAX_QUEUES(MAX_QUEUES)) ring_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .cq_phase_hint (cq_phase_hint)
  );

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("nvme_queue_pair_tracker_core_tb failed");
      $finish;
    end
  end

  function automatic in_item_t mk(input logic [CMD_W-1:0] cmd, input logic [QID_W-1:0] qid,
                                  input logic phase, input logic [SQID_W-1:0] sqid,
                                  input logic [PTR_W-1:0] sqhd);
    in_item_t it;
    it.command     = cmd;
    it.queue_id    = qid;
    it.cqe_phase   = phase;
    it.cqe_sq_id   = sqid;
    it.cqe_sq_head = sqhd;
    return it;
  endfunction

  // Mostly well-formed traffic: completions carry the phase the tracker waits for,
  // reported heads fall inside the ring, and a few queues take most of the load.
  function automatic in_item_t random_cmd();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 35)      it.command = CMD_SQ_ENQ;
    else if (r < 50) it.command = CMD_CQ_POLL;
    else if (r < 80) it.command = CMD_CQ_DEQ;
    else if (r < 88) it.command = CMD_SQ_DB;
    else if (r < 97) it.command = CMD_CQ_DB;
    else             it.command = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    it.queue_id  = ($urandom_range(0, 2) != 0) ? QID_W'($urandom_range(0, 3))
                                               : QID_W'($urandom_range(0, 15));
    it.cqe_phase = ($urandom_range(0, 4) != 0) ? cq_phase_hint : ~cq_phase_hint;
    r = $urandom_range(0, 99);
    if (r < 60)      it.cqe_sq_id = SQID_W'($urandom_range(0, 3));
    else if (r < 85) it.cqe_sq_id = SQID_W'($urandom_range(0, MAX_QUEUES - 1));
    else             it.cqe_sq_id = SQID_W'($urandom_range(0, 65535));
    it.cqe_sq_head = ($urandom_range(0, 3) != 0) ? PTR_W'($urandom_range(0, sq_slots_now - 1))
                                                 : PTR_W'($urandom_range(0, 1023));
    return it;
  endfunction

  // Present one command and hold it until the block takes it.
  task automatic send_cmd(input in_item_t it);
    int gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = it;
    start = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and let every outstanding beat come back.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] sq_slots,
                               input logic [CFG_DATA_W-1:0] cq_slots,
                               input logic [CFG_DATA_W-1:0] sq_bytes,
                               input logic [CFG_DATA_W-1:0] cq_bytes);
    wait_idle();
    write_reg(REG_SQ_ENTRIES, sq_slots);
    write_reg(REG_CQ_ENTRIES, cq_slots);
    write_reg(REG_SQ_EBYTES, sq_bytes);
    write_reg(REG_CQ_EBYTES, cq_bytes);
    sq_slots_now = (sq_slots < 2) ? 2 : ((sq_slots > 1024) ? 1024 : int'(sq_slots));
  endtask

  initial begin
    int p;
    int i;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pass at the reset configuration (64-slot rings, 64/16-byte entries).
    send_cmd(mk(CMD_SQ_DB, 4'd0, 1'b0, 16'd0, 10'd0));
    send_cmd(mk(CMD_CQ_DB, 4'd0, 1'b0, 16'd0, 10'd0));
    send_cmd(mk(CMD_SQ_ENQ, 4'd0, 1'b0, 16'd0, 10'd0));
    send_cmd(mk(CMD_SQ_ENQ, 4'd15, 1'b1, 16'hFFFF, 10'h3FF));
    send_cmd(mk(CMD_CQ_POLL, 4'd0, 1'b1, 16'd0, 10'd0));
    send_cmd(mk(CMD_CQ_POLL, 4'd15, 1'b0, 16'hFFFF, 10'h3FF));
    // stale phase: no completion, nothing moves
    send_cmd(mk(CMD_CQ_DEQ, 4'd0, 1'b0, 16'd0, 10'd5));
    send_cmd(mk(CMD_CQ_DEQ, 4'd0, 1'b1, 16'd0, 10'h3FF));
    // completion names a queue past the table: head advances, nothing stored
    send_cmd(mk(CMD_CQ_DEQ, 4'd0, 1'b1, 16'hFFFF, 10'd0));
    send_cmd(mk(CMD_CQ_DEQ, 4'd0, 1'b1, 16'd16, 10'd7));
    // park queue 1's head at 1 so its first enqueue finds the ring full
    send_cmd(mk(CMD_CQ_DEQ, 4'd0, 1'b1, 16'd1, 10'd1));
    send_cmd(mk(CMD_SQ_ENQ, 4'd1, 1'b0, 16'd0, 10'd0));
    send_cmd(mk(CMD_SQ_DB, 4'd1, 1'b0, 16'd0, 10'd0));
    send_cmd(mk(CMD_SQ_DB, 4'd0, 1'b0, 16'd0, 10'd0));
    send_cmd(mk(CMD_CQ_DB, 4'd0, 1'b0, 16'd0, 10'd0));
    send_cmd(mk(CMD_SPARE_FIRST, 4'd15, 1'b1, 16'hFFFF, 10'h3FF));
    send_cmd(mk(CMD_SPARE_LAST, 4'd15, 1'b1, 16'hFFFF, 10'h3FF));
    send_cmd(mk(CMD_SQ_ENQ, 4'd0, 1'b1, 16'd0, 10'd0));
    send_cmd(mk(CMD_CQ_DEQ, 4'd0, 1'b1, 16'd15, 10'h03F));

    // Random phases: reset values, floor, below range, ceiling, above range,
    // a shrink that strands pointers past the ring, then random small rings.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: apply_setting(11'd2, 11'd2, 11'd1, 11'd1);
        2: apply_setting(11'd0, 11'd1, 11'd0, 11'd127);
        3: apply_setting(11'd1024, 11'd1024, 11'd64, 11'd64);
        4: apply_setting(11'd2047, 11'd1500, 11'd100, 11'd65);
        5: apply_setting(11'd5, 11'd3, 11'd17, 11'd5);
        default: apply_setting(CFG_DATA_W'($urandom_range(2, 16)),
                               CFG_DATA_W'($urandom_range(2, 16)),
                               CFG_DATA_W'($urandom_range(1, 64)),
                               CFG_DATA_W'($urandom_range(1, 64)));
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // switch between back-to-back traffic and random gaps every few dozen beats
        if (i % IDLE_BLOCK == 0) gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
        // hold off mid-phase until the pipe has fully drained
        if (i == PHASE_ITEMS / 2) wait_idle();
        send_cmd(random_cmd());
      end
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("nvme_queue_pair_tracker_core_tb passed");
    end else begin
      $display("nvme_queue_pair_tracker_core_tb failed");
    end
    $finish;
  end

endmodule
